// ===== hw/rtl/gdsa_pkg.sv =====
// Shared types, constants and helpers for the grouped device slot allocator.
// Used by gdsa_list, grouped_device_slot_allocator_top and the testbench; depends on nothing.
package gdsa_pkg;

   localparam int SLOTS = 8;
   localparam int DEV_W = 3;
   localparam int CNT_W = 4;

   // Function codes of an input item.
   localparam logic [2:0] FUNC_ACQ_ONE  = 3'd0;
   localparam logic [2:0] FUNC_ACQ_MANY = 3'd1;
   localparam logic [2:0] FUNC_RELEASE  = 3'd2;
   localparam logic [2:0] FUNC_HEALTH   = 3'd3;
   localparam logic [2:0] FUNC_FAIL     = 3'd4;
   localparam logic [2:0] FUNC_RESTART  = 3'd5;

   // Register index of the only configuration register.
   localparam logic REG_INSTALL_MASK = 1'b0;

   // Operations on the free list storage.
   typedef enum logic [2:0] {
      LST_NOP,
      LST_POP,
      LST_PUSH,
      LST_CLEAR,
      LST_APPEND,
      LST_COMMIT
   } lst_op_type;

   typedef struct packed {
      lst_op_type         op;
      logic [DEV_W-1:0]   dev;
      logic [DEV_W-1:0]   rd_idx;
   } lst_cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0]   length;
      logic [SLOTS-1:0]   free_mask;
      logic [DEV_W-1:0]   entry;
   } lst_stat_type;

   // Number of set bits in an 8-bit mask.
   function automatic logic [CNT_W-1:0] popcount8(input logic [SLOTS-1:0] v);
      logic [CNT_W-1:0] n;
      n = '0;
      for (int i = 0; i < SLOTS; i++) begin
         n = n + CNT_W'(v[i]);
      end
      return n;
   endfunction

endpackage

// ===== hw/rtl/grouped_device_slot_allocator_top.sv =====
// Grouped device slot allocator: sequencer, masks, result register, APB port.
// Depends on gdsa_pkg and gdsa_list.
// Acquire one, release and health fail go straight to the result register.
// Acquire many searches groups (up to 15 with four levels), walks the list, commits.
// Health report walks the devices, then the old free list; restart walks the devices.
// One item at a time; a new item is taken when the sequencer is idle, even
// while the previous result waits. Synchronous reset restores the power-up state.
module grouped_device_slot_allocator_top #(
   parameter int LEVELS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [3:0]  req_count,
   input  logic [2:0]  req_device,
   input  logic [7:0]  req_healthy_report,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_status,
   output logic [7:0]  rsp_granted_mask,
   output logic [2:0]  rsp_granted_device,
   output logic [3:0]  rsp_total_slots,
   output logic [3:0]  rsp_free_slots,
   output logic [3:0]  rsp_used_slots,
   output logic [7:0]  rsp_lost_alerts,
   output logic        rsp_enabled_flag,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK_DEV,
      S_WALK_LIST,
      S_SEARCH,
      S_GRANT,
      S_COMMIT,
      S_DONE
   } state_type;

   localparam logic [1:0] LAST_LEVEL = 2'(LEVELS - 1);

   state_type   state_ff, state_in;
   logic [2:0]  idx_ff, idx_in;
   logic [3:0]  count_ff, count_in;
   logic [1:0]  level_ff, level_in;
   logic [2:0]  group_ff, group_in;
   logic [3:0]  taken_ff, taken_in;
   logic [7:0]  grant_ff, grant_in;
   logic [2:0]  gdev_ff, gdev_in;
   logic        status_ff, status_in;
   logic        hr_ff, hr_in;
   logic [7:0]  walk_mask_ff, walk_mask_in;
   logic [7:0]  report_ff, report_in;
   logic [7:0]  healthy_ff, healthy_in;
   logic [7:0]  acquired_ff, acquired_in;
   logic [7:0]  lost_ff, lost_in;
   logic        enabled_ff, enabled_in;
   logic [7:0]  install_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_status_ff, rsp_status_in;
   logic [7:0]  rsp_grant_ff, rsp_grant_in;
   logic [2:0]  rsp_gdev_ff, rsp_gdev_in;
   logic [3:0]  rsp_total_ff, rsp_total_in;
   logic [3:0]  rsp_free_ff, rsp_free_in;
   logic [3:0]  rsp_used_ff, rsp_used_in;
   logic [7:0]  rsp_lost_ff, rsp_lost_in;
   logic        rsp_enabled_ff, rsp_enabled_in;

   gdsa_pkg::lst_cmd_type  lst_cmd;
   gdsa_pkg::lst_stat_type lst_stat;

   logic [7:0]  group_mask;
   logic [3:0]  group_hits;
   logic [3:0]  total_cnt;
   logic [7:0]  lost_new;
   logic [7:0]  returning;
   logic [2:0]  entry_group;
   logic        rsp_slot_free;

   gdsa_list u_list (
      .clock (clock),
      .reset (reset),
      .cmd   (lst_cmd),
      .stat  (lst_stat)
   );

   // Configuration port: one register, always ready.
   assign pready = 1'b1;
   assign prdata = {24'd0, install_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         install_ff <= 8'hFF;
      end else if (psel && penable && pwrite && pready
                   && paddr[2] == gdsa_pkg::REG_INSTALL_MASK) begin
         install_ff <= pwdata[7:0];
      end
   end

   // Shared compare unit: free members of the current group against the count.
   always_comb begin
      for (int d = 0; d < gdsa_pkg::SLOTS; d++) begin
         group_mask[d] = ((3'(d) >> level_ff) == group_ff);
      end
   end
   assign group_hits  = gdsa_pkg::popcount8(lst_stat.free_mask & group_mask);
   assign entry_group = lst_stat.entry >> level_ff;
   assign total_cnt   = gdsa_pkg::popcount8(healthy_ff);
   assign lost_new    = lost_ff | (healthy_ff & ~req_healthy_report);
   assign returning   = req_healthy_report & lost_new;

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_slot_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer next-state logic.
   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      count_in       = count_ff;
      level_in       = level_ff;
      group_in       = group_ff;
      taken_in       = taken_ff;
      grant_in       = grant_ff;
      gdev_in        = gdev_ff;
      status_in      = status_ff;
      hr_in          = hr_ff;
      walk_mask_in   = walk_mask_ff;
      report_in      = report_ff;
      healthy_in     = healthy_ff;
      acquired_in    = acquired_ff;
      lost_in        = lost_ff;
      enabled_in     = enabled_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_grant_in   = rsp_grant_ff;
      rsp_gdev_in    = rsp_gdev_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_free_in    = rsp_free_ff;
      rsp_used_in    = rsp_used_ff;
      rsp_lost_in    = rsp_lost_ff;
      rsp_enabled_in = rsp_enabled_ff;
      lst_cmd.op     = gdsa_pkg::LST_NOP;
      lst_cmd.dev    = '0;
      lst_cmd.rd_idx = idx_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               status_in = 1'b0;
               grant_in  = '0;
               gdev_in   = '0;
               count_in  = req_count;
               idx_in    = '0;
               state_in  = S_DONE;
               case (req_func)
                  gdsa_pkg::FUNC_ACQ_ONE: begin
                     if (lst_stat.length == '0) begin
                        status_in = 1'b1;
                     end else begin
                        lst_cmd.rd_idx = 3'(lst_stat.length - 4'd1);
                        lst_cmd.op     = gdsa_pkg::LST_POP;
                        gdev_in        = lst_stat.entry;
                        grant_in       = 8'(1) << lst_stat.entry;
                        acquired_in    = acquired_ff | (8'(1) << lst_stat.entry);
                     end
                  end
                  gdsa_pkg::FUNC_ACQ_MANY: begin
                     if (req_count > lst_stat.length) begin
                        status_in = 1'b1;
                     end else if (req_count != '0) begin
                        level_in = '0;
                        group_in = '0;
                        state_in = S_SEARCH;
                     end
                  end
                  gdsa_pkg::FUNC_RELEASE: begin
                     if (acquired_ff[req_device]) begin
                        acquired_in[req_device] = 1'b0;
                        if (healthy_ff[req_device]) begin
                           lst_cmd.op  = gdsa_pkg::LST_PUSH;
                           lst_cmd.dev = req_device;
                        end else begin
                           lost_in[req_device] = 1'b1;
                        end
                     end
                  end
                  gdsa_pkg::FUNC_HEALTH: begin
                     lost_in      = lost_new & ~returning;
                     walk_mask_in = returning & ~acquired_ff;
                     report_in    = req_healthy_report;
                     healthy_in   = req_healthy_report;
                     enabled_in   = 1'b1;
                     hr_in        = 1'b1;
                     lst_cmd.op   = gdsa_pkg::LST_CLEAR;
                     state_in     = S_WALK_DEV;
                  end
                  gdsa_pkg::FUNC_FAIL: begin
                     enabled_in = 1'b0;
                  end
                  gdsa_pkg::FUNC_RESTART: begin
                     healthy_in   = install_ff;
                     acquired_in  = '0;
                     lost_in      = '0;
                     enabled_in   = 1'b0;
                     walk_mask_in = install_ff;
                     hr_in        = 1'b0;
                     lst_cmd.op   = gdsa_pkg::LST_CLEAR;
                     state_in     = S_WALK_DEV;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Append the marked devices in ascending order.
         S_WALK_DEV: begin
            if (walk_mask_ff[idx_ff]) begin
               lst_cmd.op  = gdsa_pkg::LST_APPEND;
               lst_cmd.dev = idx_ff;
            end
            if (idx_ff == 3'(gdsa_pkg::SLOTS - 1)) begin
               idx_in = '0;
               if (hr_ff && lst_stat.length != '0) begin
                  state_in = S_WALK_LIST;
               end else begin
                  state_in = S_COMMIT;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         // Keep reported entries of the old list, skipping ones already placed.
         S_WALK_LIST: begin
            if (report_ff[lst_stat.entry] && !walk_mask_ff[lst_stat.entry]) begin
               lst_cmd.op                   = gdsa_pkg::LST_APPEND;
               lst_cmd.dev                  = lst_stat.entry;
               walk_mask_in[lst_stat.entry] = 1'b1;
            end
            if (4'(idx_ff) == lst_stat.length - 4'd1) begin
               state_in = S_COMMIT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         // One group per cycle, levels ascending, groups ascending.
         S_SEARCH: begin
            if (group_hits != '0 && group_hits >= count_ff) begin
               idx_in     = '0;
               taken_in   = '0;
               lst_cmd.op = gdsa_pkg::LST_CLEAR;
               state_in   = S_GRANT;
            end else if (group_ff == (3'(gdsa_pkg::SLOTS - 1) >> level_ff)) begin
               if (level_ff == LAST_LEVEL) begin
                  status_in = 1'b1;
                  state_in  = S_DONE;
               end else begin
                  level_in = level_ff + 1'b1;
                  group_in = '0;
               end
            end else begin
               group_in = group_ff + 1'b1;
            end
         end

         // Walk the list: grant group members until the count is met, keep the rest.
         S_GRANT: begin
            if (entry_group == group_ff && taken_ff < count_ff) begin
               grant_in[lst_stat.entry] = 1'b1;
               taken_in                 = taken_ff + 1'b1;
            end else begin
               lst_cmd.op  = gdsa_pkg::LST_APPEND;
               lst_cmd.dev = lst_stat.entry;
            end
            if (4'(idx_ff) == lst_stat.length - 4'd1) begin
               state_in = S_COMMIT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         S_COMMIT: begin
            lst_cmd.op  = gdsa_pkg::LST_COMMIT;
            acquired_in = acquired_ff | grant_ff;
            state_in    = S_DONE;
         end

         // Load the result register once it is free.
         S_DONE: begin
            if (rsp_slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_grant_in   = grant_ff;
               rsp_gdev_in    = gdev_ff;
               rsp_lost_in    = lost_ff;
               rsp_enabled_in = enabled_ff;
               if (enabled_ff) begin
                  rsp_total_in = total_cnt;
                  rsp_free_in  = lst_stat.length;
                  rsp_used_in  = (total_cnt >= lst_stat.length) ?
                                 total_cnt - lst_stat.length : 4'd0;
               end else begin
                  rsp_total_in = '0;
                  rsp_free_in  = '0;
                  rsp_used_in  = '0;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, masks and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         hr_ff        <= 1'b0;
         healthy_ff   <= 8'hFF;
         acquired_ff  <= '0;
         lost_ff      <= '0;
         enabled_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         hr_ff        <= hr_in;
         healthy_ff   <= healthy_in;
         acquired_ff  <= acquired_in;
         lost_ff      <= lost_in;
         enabled_ff   <= enabled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      count_ff       <= count_in;
      level_ff       <= level_in;
      group_ff       <= group_in;
      taken_ff       <= taken_in;
      grant_ff       <= grant_in;
      gdev_ff        <= gdev_in;
      status_ff      <= status_in;
      walk_mask_ff   <= walk_mask_in;
      report_ff      <= report_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_grant_ff   <= rsp_grant_in;
      rsp_gdev_ff    <= rsp_gdev_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_free_ff    <= rsp_free_in;
      rsp_used_ff    <= rsp_used_in;
      rsp_lost_ff    <= rsp_lost_in;
      rsp_enabled_ff <= rsp_enabled_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_granted_mask   = rsp_grant_ff;
   assign rsp_granted_device = rsp_gdev_ff;
   assign rsp_total_slots    = rsp_total_ff;
   assign rsp_free_slots     = rsp_free_ff;
   assign rsp_used_slots     = rsp_used_ff;
   assign rsp_lost_alerts    = rsp_lost_ff;
   assign rsp_enabled_flag   = rsp_enabled_ff;

endmodule

// ===== hw/rtl/gdsa_list.sv =====
// Ordered free list storage with a scratch list used to rebuild it.
// Depends on gdsa_pkg for the command and status types.
module gdsa_list (
   input  logic                 clock,
   input  logic                 reset,
   input  gdsa_pkg::lst_cmd_type cmd,
   output gdsa_pkg::lst_stat_type stat
);

   logic [gdsa_pkg::DEV_W-1:0] list_ff    [gdsa_pkg::SLOTS];
   logic [gdsa_pkg::DEV_W-1:0] scratch_ff [gdsa_pkg::SLOTS];
   logic [gdsa_pkg::CNT_W-1:0] length_ff;
   logic [gdsa_pkg::CNT_W-1:0] scr_n_ff;
   logic [gdsa_pkg::SLOTS-1:0] free_mask;

   // Membership mask of the devices held in the valid part of the list.
   always_comb begin
      free_mask = '0;
      for (int i = 0; i < gdsa_pkg::SLOTS; i++) begin
         if (gdsa_pkg::CNT_W'(i) < length_ff) begin
            free_mask[list_ff[i]] = 1'b1;
         end
      end
   end

   assign stat.length    = length_ff;
   assign stat.free_mask = free_mask;
   assign stat.entry     = list_ff[cmd.rd_idx];

   // The list resets to ascending device indices; the scratch list is payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < gdsa_pkg::SLOTS; i++) begin
            list_ff[i] <= gdsa_pkg::DEV_W'(i);
         end
         length_ff <= gdsa_pkg::CNT_W'(gdsa_pkg::SLOTS);
         scr_n_ff  <= '0;
      end else begin
         case (cmd.op)
            gdsa_pkg::LST_POP: begin
               if (length_ff != '0) begin
                  length_ff <= length_ff - 1'b1;
               end
            end
            gdsa_pkg::LST_PUSH: begin
               if (length_ff < gdsa_pkg::CNT_W'(gdsa_pkg::SLOTS)) begin
                  list_ff[length_ff[gdsa_pkg::DEV_W-1:0]] <= cmd.dev;
                  length_ff <= length_ff + 1'b1;
               end
            end
            gdsa_pkg::LST_CLEAR: begin
               scr_n_ff <= '0;
            end
            gdsa_pkg::LST_APPEND: begin
               if (scr_n_ff < gdsa_pkg::CNT_W'(gdsa_pkg::SLOTS)) begin
                  scratch_ff[scr_n_ff[gdsa_pkg::DEV_W-1:0]] <= cmd.dev;
                  scr_n_ff <= scr_n_ff + 1'b1;
               end
            end
            gdsa_pkg::LST_COMMIT: begin
               for (int i = 0; i < gdsa_pkg::SLOTS; i++) begin
                  list_ff[i] <= scratch_ff[i];
               end
               length_ff <= scr_n_ff;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

// ===== hw/rtl/gdsa_checker.sv =====
// Port-level checks for the grouped device slot allocator, bound to its top.
// Depends only on the top level's ports.
module gdsa_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_status,
   input logic [7:0] rsp_granted_mask,
   input logic [2:0] rsp_granted_device,
   input logic [3:0] rsp_total_slots,
   input logic [3:0] rsp_free_slots,
   input logic [3:0] rsp_used_slots,
   input logic       rsp_enabled_flag
);

   // A stalled result item holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_granted_mask)
                                 && $stable(rsp_status))
      else $error("stalled result item changed");

   // An accepted item keeps the sequencer busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again right after an accept");

   // Counts are zero while disabled.
   a_disabled_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_enabled_flag |-> rsp_total_slots == 4'd0
         && rsp_free_slots == 4'd0 && rsp_used_slots == 4'd0)
      else $error("counts shown while disabled");

   // A failed acquire grants nothing.
   a_fail_no_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_granted_mask == 8'd0
         && rsp_granted_device == 3'd0)
      else $error("grant reported with failure status");

   // Used slots never exceed the total.
   a_used_le_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_used_slots <= rsp_total_slots)
      else $error("used slots above total");

endmodule

bind grouped_device_slot_allocator_top gdsa_checker u_gdsa_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_status         (rsp_status),
   .rsp_granted_mask   (rsp_granted_mask),
   .rsp_granted_device (rsp_granted_device),
   .rsp_total_slots    (rsp_total_slots),
   .rsp_free_slots     (rsp_free_slots),
   .rsp_used_slots     (rsp_used_slots),
   .rsp_enabled_flag   (rsp_enabled_flag)
);

// ===== tb/sv/gdsa_tb_pkg.sv =====
// Testbench types and the result scoreboard for the grouped device slot allocator.
// Depends on gdsa_pkg for the function codes; used by tb_grouped_device_slot_allocator_top.
package gdsa_tb_pkg;

   import gdsa_pkg::*;

   // Search depth of acquire many; matches the default of the block.
   localparam int ALLOC_LEVELS = 4;

   // Function codes that the block must treat as no operation.
   localparam logic [2:0] FUNC_SPARE6 = 3'd6;
   localparam logic [2:0] FUNC_SPARE7 = 3'd7;

   // One request item as driven on the input channel.
   typedef struct packed {
      logic [2:0] func;
      logic [3:0] count;
      logic [2:0] device;
      logic [7:0] report;
   } slot_req_t;

   // One result item as seen on the output channel.
   typedef struct packed {
      logic       status;
      logic [7:0] granted_mask;
      logic [2:0] granted_device;
      logic [3:0] total_slots;
      logic [3:0] free_slots;
      logic [3:0] used_slots;
      logic [7:0] lost_alerts;
      logic       enabled_flag;
   } slot_rsp_t;

   // Tracks the allocator state and queues the result owed for each request.
   class slot_scoreboard;
      logic [7:0]  install_mask;
      logic [2:0]  free_list [8];
      int unsigned free_len;
      logic [7:0]  healthy;
      logic [7:0]  acquired;
      logic [7:0]  lost;
      bit          enabled;
      slot_rsp_t   grant_q [$];
      int unsigned errors;

      function new();
         install_mask = 8'hFF;
         errors = 0;
         reload();
      endfunction

      function int unsigned pending();
         return grant_q.size();
      endfunction

      // Restart loads the installed devices in ascending order.
      function void reload();
         free_len = 0;
         for (int i = 0; i < 8; i++) begin
            free_list[i] = '0;
         end
         for (int i = 0; i < 8; i++) begin
            if (install_mask[i]) begin
               free_list[free_len] = 3'(i);
               free_len++;
            end
         end
         healthy = install_mask;
         acquired = '0;
         lost = '0;
         enabled = 1'b0;
      endfunction

      // Removes the devices of a mask from the free list, keeping the order.
      function void drop_from_free(logic [7:0] mask);
         logic [2:0]  kept [8];
         int unsigned n;
         n = 0;
         for (int i = 0; i < 8; i++) begin
            kept[i] = '0;
         end
         for (int i = 0; i < free_len; i++) begin
            if (!mask[free_list[i]]) begin
               kept[n] = free_list[i];
               n++;
            end
         end
         free_list = kept;
         free_len = n;
      endfunction

      // Finds the first group, by level and then index, with enough free members.
      function logic [7:0] pick_group(int unsigned want, output bit ok);
         int unsigned members;
         logic [7:0]  m;
         ok = 1'b0;
         for (int lvl = 0; lvl < ALLOC_LEVELS; lvl++) begin
            for (int g = 0; g < (8 >> lvl); g++) begin
               members = 0;
               for (int i = 0; i < free_len; i++) begin
                  if ((int'(free_list[i]) >> lvl) == g) members++;
               end
               if (members != 0 && members >= want) begin
                  m = '0;
                  members = 0;
                  for (int i = 0; i < free_len && members < want; i++) begin
                     if ((int'(free_list[i]) >> lvl) == g) begin
                        m[free_list[i]] = 1'b1;
                        members++;
                     end
                  end
                  ok = 1'b1;
                  return m;
               end
            end
         end
         return '0;
      endfunction

      // A health report rebuilds the free list: returning devices first, then old entries.
      function void apply_report(logic [7:0] rep);
         logic [2:0]  fresh [8];
         int unsigned n;
         logic [7:0]  added;
         logic [7:0]  back;
         n = 0;
         added = '0;
         for (int i = 0; i < 8; i++) begin
            fresh[i] = '0;
         end
         lost = lost | (healthy & ~rep);
         back = rep & lost;
         for (int i = 0; i < 8; i++) begin
            if (back[i] && !acquired[i]) begin
               fresh[n] = 3'(i);
               n++;
               added[i] = 1'b1;
            end
         end
         lost = lost & ~back;
         healthy = rep;
         for (int i = 0; i < free_len; i++) begin
            if (rep[free_list[i]] && !added[free_list[i]] && n < 8) begin
               fresh[n] = free_list[i];
               n++;
               added[free_list[i]] = 1'b1;
            end
         end
         free_list = fresh;
         free_len = n;
         enabled = 1'b1;
      endfunction

      // Applies an accepted request item and queues the result it owes.
      function void note_request(slot_req_t it);
         slot_rsp_t   r;
         logic [7:0]  m;
         bit          ok;
         int unsigned total;
         r = '0;
         case (it.func)
            FUNC_ACQ_ONE: begin
               if (free_len == 0) begin
                  r.status = 1'b1;
               end else begin
                  free_len--;
                  r.granted_device = free_list[free_len];
                  r.granted_mask = 8'b1 << free_list[free_len];
                  acquired = acquired | r.granted_mask;
               end
            end
            FUNC_ACQ_MANY: begin
               if (it.count > free_len) begin
                  r.status = 1'b1;
               end else if (it.count > 0) begin
                  m = pick_group(it.count, ok);
                  if (!ok) begin
                     r.status = 1'b1;
                  end else begin
                     r.granted_mask = m;
                     drop_from_free(m);
                     acquired = acquired | m;
                  end
               end
            end
            FUNC_RELEASE: begin
               if (acquired[it.device]) begin
                  acquired[it.device] = 1'b0;
                  if (!healthy[it.device]) begin
                     lost[it.device] = 1'b1;
                  end else if (free_len < 8) begin
                     free_list[free_len] = it.device;
                     free_len++;
                  end
               end
            end
            FUNC_HEALTH:  apply_report(it.report);
            FUNC_FAIL:    enabled = 1'b0;
            FUNC_RESTART: reload();
            default: ;
         endcase
         // Counts are reported only while enabled.
         if (enabled) begin
            total = $countones(healthy);
            r.total_slots = 4'(total);
            r.free_slots = 4'(free_len);
            r.used_slots = (total >= free_len) ? 4'(total - free_len) : 4'd0;
         end
         r.lost_alerts = lost;
         r.enabled_flag = enabled;
         grant_q.push_back(r);
      endfunction

      function void cmp_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      // Compares a result item with the oldest queued one.
      function void check_result(slot_rsp_t got);
         slot_rsp_t want;
         if (grant_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = grant_q.pop_front();
         cmp_field("status", want.status, got.status);
         cmp_field("granted_mask", want.granted_mask, got.granted_mask);
         cmp_field("granted_device", want.granted_device, got.granted_device);
         cmp_field("total_slots", want.total_slots, got.total_slots);
         cmp_field("free_slots", want.free_slots, got.free_slots);
         cmp_field("used_slots", want.used_slots, got.used_slots);
         cmp_field("lost_alerts", want.lost_alerts, got.lost_alerts);
         cmp_field("enabled_flag", want.enabled_flag, got.enabled_flag);
      endfunction
   endclass

endpackage

// ===== tb/sv/tb_grouped_device_slot_allocator_top.sv =====
// Top of the testbench: drives requests and APB writes into the slot allocator.
// Depends on gdsa_pkg, gdsa_tb_pkg and grouped_device_slot_allocator_top.
module tb_grouped_device_slot_allocator_top;

   timeunit 1ns;
   timeprecision 1ps;

   import gdsa_pkg::*;
   import gdsa_tb_pkg::*;

   localparam logic [2:0] INSTALL_MASK_ADDR = {REG_INSTALL_MASK, 2'b00};
   localparam int         HOLD_CYCLES = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_func = '0;
   logic [3:0]  req_count = '0;
   logic [2:0]  req_device = '0;
   logic [7:0]  req_healthy_report = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_status;
   logic [7:0]  rsp_granted_mask;
   logic [2:0]  rsp_granted_device;
   logic [3:0]  rsp_total_slots;
   logic [3:0]  rsp_free_slots;
   logic [3:0]  rsp_used_slots;
   logic [7:0]  rsp_lost_alerts;
   logic        rsp_enabled_flag;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   slot_scoreboard sb = new();
   bit             quiet = 1'b0;
   bit             hold_req = 1'b0;
   int             hold_left = 0;

   grouped_device_slot_allocator_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_count(req_count),
      .req_device(req_device),
      .req_healthy_report(req_healthy_report),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_granted_mask(rsp_granted_mask),
      .rsp_granted_device(rsp_granted_device),
      .rsp_total_slots(rsp_total_slots),
      .rsp_free_slots(rsp_free_slots),
      .rsp_used_slots(rsp_used_slots),
      .rsp_lost_alerts(rsp_lost_alerts),
      .rsp_enabled_flag(rsp_enabled_flag),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #5 clock = ~clock;

   // Result side: random stalls, a quiet stretch, and a long hold-off on request.
   always @(posedge clock) begin
      if (hold_req) begin
         hold_req = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 32);
      end
   end

   // Every accepted result item is checked against the oldest queued one.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result('{rsp_status, rsp_granted_mask, rsp_granted_device,
                           rsp_total_slots, rsp_free_slots, rsp_used_slots,
                           rsp_lost_alerts, rsp_enabled_flag});
      end
   end

   // APB write: a setup phase, then an access phase until pready.
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read(input logic [2:0] addr, output logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= addr;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      data = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Sets the install mask and reads it back.
   task automatic load_install_mask(input logic [7:0] mask);
      logic [31:0] rd;
      csr_write(INSTALL_MASK_ADDR, {24'd0, mask});
      csr_read(INSTALL_MASK_ADDR, rd);
      if (rd[7:0] !== mask) begin
         $display("%0t: install_mask readback, expected %0h, actual %0h", $time, mask, rd[7:0]);
         sb.errors++;
      end
      sb.install_mask = mask;
   endtask

   // Offers one request item after a random gap and waits until it is taken.
   task automatic send_request(input slot_req_t it);
      int gap;
      gap = 0;
      if (!quiet) begin
         while ($urandom_range(99) < 32) gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= it.func;
      req_count <= it.count;
      req_device <= it.device;
      req_healthy_report <= it.report;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(it);
   endtask

   // Stops offering items until every queued result has arrived.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic slot_req_t mk(logic [2:0] func, logic [3:0] count,
                                    logic [2:0] device, logic [7:0] report);
      slot_req_t it;
      it.func = func;
      it.count = count;
      it.device = device;
      it.report = report;
      return it;
   endfunction

   // Random request, biased toward sound use of the current allocator state.
   function automatic slot_req_t rand_request();
      slot_req_t it;
      int        roll;
      int        held [$];
      roll = $urandom_range(99);
      it.func = FUNC_ACQ_ONE;
      it.count = 4'($urandom_range(15));
      it.device = 3'($urandom_range(7));
      it.report = 8'($urandom_range(255));
      if (roll < 28) begin
         it.func = FUNC_ACQ_ONE;
      end else if (roll < 52) begin
         it.func = FUNC_ACQ_MANY;
         if ($urandom_range(3) != 0 && sb.free_len > 0) begin
            it.count = 4'($urandom_range(sb.free_len, 1));
         end
      end else if (roll < 80) begin
         it.func = FUNC_RELEASE;
         for (int i = 0; i < 8; i++) begin
            if (sb.acquired[i]) held.push_back(i);
         end
         if (held.size() != 0 && $urandom_range(7) != 0) begin
            it.device = 3'(held[$urandom_range(held.size() - 1)]);
         end
      end else if (roll < 90) begin
         it.func = FUNC_HEALTH;
         case ($urandom_range(2))
            0: it.report = 8'hFF;
            1: it.report = sb.healthy ^ (8'b1 << $urandom_range(7));
            default: ;
         endcase
      end else if (roll < 94) begin
         it.func = FUNC_FAIL;
      end else if (roll < 97) begin
         it.func = FUNC_RESTART;
      end else begin
         it.func = $urandom_range(1) ? FUNC_SPARE6 : FUNC_SPARE7;
      end
      return it;
   endfunction

   // Main sequence: reset, directed items, then phases over several install masks.
   initial begin
      slot_req_t   plan [$];
      logic [7:0]  masks [8];
      int          sizes [8];
      masks = '{8'hFF, 8'h00, 8'h5A, 8'h01, 8'h80, 8'h00, 8'hF0, 8'h00};
      sizes = '{130, 40, 130, 130, 130, 130, 130, 130};
      masks[5] = 8'($urandom_range(255));
      masks[7] = 8'($urandom_range(255));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items from the reset state.
      plan.push_back(mk(FUNC_ACQ_MANY, 4'd0, 3'd0, 8'h00));
      plan.push_back(mk(FUNC_ACQ_ONE, 4'd0, 3'd0, 8'h00));
      plan.push_back(mk(FUNC_HEALTH, 4'd0, 3'd0, 8'hFF));
      plan.push_back(mk(FUNC_ACQ_MANY, 4'd15, 3'd0, 8'h00));
      plan.push_back(mk(FUNC_ACQ_MANY, 4'd8, 3'd0, 8'h00));
      plan.push_back(mk(FUNC_RELEASE, 4'd0, 3'd7, 8'h00));
      plan.push_back(mk(FUNC_RELEASE, 4'd0, 3'd7, 8'h00));
      plan.push_back(mk(FUNC_ACQ_MANY, 4'd8, 3'd0, 8'h00));
      plan.push_back(mk(FUNC_ACQ_ONE, 4'd0, 3'd0, 8'h00));
      plan.push_back(mk(FUNC_RELEASE, 4'd0, 3'd3, 8'h00));
      plan.push_back(mk(FUNC_RELEASE, 4'd0, 3'd5, 8'h00));
      plan.push_back(mk(FUNC_ACQ_MANY, 4'd2, 3'd0, 8'h00));
      plan.push_back(mk(FUNC_RELEASE, 4'd0, 3'd0, 8'h00));
      plan.push_back(mk(FUNC_RELEASE, 4'd0, 3'd1, 8'h00));
      plan.push_back(mk(FUNC_HEALTH, 4'd0, 3'd0, 8'h0F));
      plan.push_back(mk(FUNC_RELEASE, 4'd0, 3'd4, 8'h00));
      plan.push_back(mk(FUNC_HEALTH, 4'd0, 3'd0, 8'hFF));
      plan.push_back(mk(FUNC_ACQ_MANY, 4'd2, 3'd0, 8'h00));
      plan.push_back(mk(FUNC_FAIL, 4'd0, 3'd0, 8'h00));
      plan.push_back(mk(FUNC_ACQ_ONE, 4'd0, 3'd0, 8'h00));
      plan.push_back(mk(FUNC_SPARE6, 4'd15, 3'd7, 8'hFF));
      plan.push_back(mk(FUNC_SPARE7, 4'd9, 3'd5, 8'hAA));
      plan.push_back(mk(FUNC_RESTART, 4'd0, 3'd0, 8'h00));
      plan.push_back(mk(FUNC_RELEASE, 4'd0, 3'd2, 8'h00));
      plan.push_back(mk(FUNC_ACQ_MANY, 4'd1, 3'd0, 8'h00));

      for (int p = 0; p < 8; p++) begin
         // The register is only written while nothing is in flight.
         drain();
         quiet = (p == 2);
         load_install_mask(masks[p]);
         if (p == 0) begin
            foreach (plan[k]) send_request(plan[k]);
         end else begin
            send_request(mk(FUNC_RESTART, 4'($urandom_range(15)),
                            3'($urandom_range(7)), 8'($urandom_range(255))));
         end
         // Let the block fill up while the result side holds off.
         if (p == 4) hold_req = 1'b1;
         for (int n = 0; n < sizes[p]; n++) begin
            send_request(rand_request());
         end
      end

      drain();
      quiet = 1'b0;
      repeat (40) @(posedge clock);
      if (sb.errors == 0) begin
         $display("[grouped_device_slot_allocator_top] OK");
      end else begin
         $display("[grouped_device_slot_allocator_top] ERROR");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #5000000;
      $display("[grouped_device_slot_allocator_top] ERROR");
      $finish;
   end

endmodule
